@@ src/vfed_pkg.sv @@
package vfed_pkg;

    localparam logic [28:0] ID_DIAG_REPLY = 29'h0080_0003;
    localparam logic [28:0] ID_REMOTE     = 29'h0240_162A;
    localparam logic [28:0] ID_WHEEL      = 29'h0040_4066;
    localparam logic [28:0] ID_CLIMATE    = 29'h0440_0002;
    localparam logic [28:0] ID_BRIGHT     = 29'h02C1_4DF4;
    localparam logic [28:0] ID_SPEED      = 29'h0121_77FC;
    localparam logic [28:0] ID_RPM        = 29'h02C1_3428;

    localparam logic [7:0] DIAG_MODULE_ADDR = 8'h40;
    localparam logic [7:0] DIAG_BATTERY     = 8'h02;
    localparam logic [7:0] DIAG_MILEAGE     = 8'h11;

    localparam logic [3:0] KEY_LOCK   = 4'hB;
    localparam logic [3:0] KEY_UNLOCK = 4'hA;

    localparam logic [7:0] MEDIA_RELEASE = 8'h7F;
    localparam logic [7:0] MEDIA_NEXT_BT = 8'h7D;
    localparam logic [7:0] MEDIA_PREV_BT = 8'h7E;
    localparam logic [7:0] MEDIA_RAISE   = 8'h77;
    localparam logic [7:0] MEDIA_LOWER   = 8'h7B;
    localparam logic [7:0] CRUISE_RAISE  = 8'h42;
    localparam logic [7:0] CRUISE_LOWER  = 8'h44;

    localparam logic [7:0] NAV_RELEASE  = 8'h40;
    localparam logic [7:0] NAV_UP_BT    = 8'h48;
    localparam logic [7:0] NAV_DOWN_BT  = 8'h44;
    localparam logic [7:0] NAV_LEFT_BT  = 8'h42;
    localparam logic [7:0] NAV_RIGHT_BT = 8'h41;
    localparam logic [7:0] NAV_BACK_BT  = 8'h50;
    localparam logic [7:0] NAV_ENTER_BT = 8'h60;

    localparam logic [15:0] PRESS_WINDOW_RESET = 16'd2000;
    localparam logic [15:0] REVERSE_HOLD_RESET = 16'd7500;
    localparam logic [12:0] CABIN_RESET        = 13'd3;

    localparam logic CFG_PRESS_WINDOW = 1'b0;
    localparam logic CFG_REVERSE_HOLD = 1'b1;

    typedef enum logic [1:0] {
        MEDIA_NONE = 2'd0,
        MEDIA_NEXT = 2'd1,
        MEDIA_PREV = 2'd2
    } media_ev_t;

    typedef enum logic [2:0] {
        NAV_NONE  = 3'd0,
        NAV_UP    = 3'd1,
        NAV_DOWN  = 3'd2,
        NAV_LEFT  = 3'd3,
        NAV_RIGHT = 3'd4,
        NAV_BACK  = 3'd5,
        NAV_ENTER = 3'd6
    } nav_ev_t;

    typedef enum logic [2:0] {
        DISP_NONE    = 3'd0,
        DISP_RAISE   = 3'd1,
        DISP_LOWER   = 3'd2,
        DISP_REVERSE = 3'd3,
        DISP_LEVEL   = 3'd4
    } disp_cmd_t;

    typedef enum logic [1:0] {
        VIDEO_KEEP     = 2'd0,
        VIDEO_COMPUTER = 2'd1,
        VIDEO_CAMERA   = 2'd2
    } video_sel_t;

    typedef enum logic [1:0] {
        BODY_NONE        = 2'd0,
        BODY_LIGHTS      = 2'd1,
        BODY_LIGHTS_OPEN = 2'd2,
        BODY_CLOSE       = 2'd3
    } body_act_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] count;
    } press_t;

    // A press inside the window advances the count; the second one fires and clears it.
    function automatic press_t count_press(input logic [31:0] now, input logic [31:0] last,
                                           input logic [1:0] count, input logic [15:0] window);
        logic [31:0] elapsed;
        logic [1:0]  cnt;
        press_t      res;
        elapsed = now - last;
        cnt = (elapsed < {16'd0, window}) ? count + 2'd1 : 2'd0;
        res.fire = (cnt == 2'd2);
        res.count = res.fire ? 2'd0 : cnt;
        return res;
    endfunction

endpackage

@@ src/vehicle_frame_event_decoder.sv @@
// A frame transferred into the input register is decoded into the output register once
// that stage can advance, and its result is then valid on the m_ channel.
// Throughput: one frame per cycle; s_ready drops only while both registers are full
// and m_ready is low.
// Reset (aresetn low, synchronous): both stages empty, decoder state cleared, cabin
// value 3, press window 2000 ms and reverse hold 7500 ms.
module vehicle_frame_event_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [28:0]        s_frame_id,
    input  logic [31:0]        s_now_ms,
    input  logic [7:0]         s_byte1,
    input  logic [7:0]         s_byte2,
    input  logic [7:0]         s_byte3,
    input  logic [7:0]         s_byte4,
    input  logic [7:0]         s_byte5,
    input  logic [7:0]         s_byte6,
    input  logic [7:0]         s_byte7,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_media_event,
    output logic [2:0]         m_nav_event,
    output logic [2:0]         m_display_cmd,
    output logic signed [8:0]  m_display_level,
    output logic [1:0]         m_video_select,
    output logic [1:0]         m_body_action,
    output logic [7:0]         m_speed_value,
    output logic [11:0]        m_rpm_value,
    output logic [11:0]        m_battery_value,
    output logic [31:0]        m_mileage_value,
    output logic [12:0]        m_cabin_value,
    output logic               m_reverse_flag
);
    import vfed_pkg::*;

    logic        in_valid_reg;
    logic [28:0] frame_id_reg;
    logic [31:0] now_reg;
    logic [7:0]  b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg;

    logic [15:0] press_window_reg;
    logic [15:0] reverse_hold_reg;

    logic               media_held_reg, media_held_next;
    logic               nav_held_reg, nav_held_next;
    logic               keep_display_reg, keep_display_next;
    logic signed [8:0]  brightness_reg, brightness_next;
    logic [31:0]        reverse_deadline_reg, reverse_deadline_next;
    logic [31:0]        lock_last_reg, lock_last_next;
    logic [1:0]         lock_count_reg, lock_count_next;
    logic [31:0]        unlock_last_reg, unlock_last_next;
    logic [1:0]         unlock_count_reg, unlock_count_next;
    logic [11:0]        battery_reg, battery_next;
    logic [31:0]        mileage_reg, mileage_next;
    logic [12:0]        cabin_reg, cabin_next;
    logic [7:0]         speed_reg, speed_next;
    logic [11:0]        rpm_reg, rpm_next;
    logic               reverse_reg, reverse_next;

    logic               out_valid_reg;
    media_ev_t          media_reg, media_next;
    nav_ev_t            nav_reg, nav_next;
    disp_cmd_t          disp_reg, disp_next;
    logic signed [8:0]  level_reg, level_next;
    video_sel_t         video_reg, video_next;
    body_act_t          body_reg, body_next;

    logic        advance;
    logic        load_in;
    logic        fire;
    logic [12:0] times25;
    logic [31:0] rev_dist;
    press_t      lock_press;
    press_t      unlock_press;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign load_in = s_valid && s_ready;
    assign fire    = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            frame_id_reg <= s_frame_id;
            now_reg      <= s_now_ms;
            b1_reg       <= s_byte1;
            b2_reg       <= s_byte2;
            b3_reg       <= s_byte3;
            b4_reg       <= s_byte4;
            b5_reg       <= s_byte5;
            b6_reg       <= s_byte6;
            b7_reg       <= s_byte7;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_window_reg <= PRESS_WINDOW_RESET;
            reverse_hold_reg <= REVERSE_HOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRESS_WINDOW: press_window_reg <= cfg_data;
                CFG_REVERSE_HOLD: reverse_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign times25      = {b5_reg, 5'd0} - {2'd0, b5_reg, 3'd0} + {5'd0, b5_reg};
    assign rev_dist     = now_reg - reverse_deadline_reg;
    assign lock_press   = count_press(now_reg, lock_last_reg, lock_count_reg, press_window_reg);
    assign unlock_press = count_press(now_reg, unlock_last_reg, unlock_count_reg,
                                      press_window_reg);

    always_comb begin
        media_held_next       = media_held_reg;
        nav_held_next         = nav_held_reg;
        keep_display_next     = keep_display_reg;
        brightness_next       = brightness_reg;
        reverse_deadline_next = reverse_deadline_reg;
        lock_last_next        = lock_last_reg;
        lock_count_next       = lock_count_reg;
        unlock_last_next      = unlock_last_reg;
        unlock_count_next     = unlock_count_reg;
        battery_next          = battery_reg;
        mileage_next          = mileage_reg;
        cabin_next            = cabin_reg;
        speed_next            = speed_reg;
        rpm_next              = rpm_reg;
        reverse_next          = reverse_reg;
        media_next            = MEDIA_NONE;
        nav_next              = NAV_NONE;
        disp_next             = DISP_NONE;
        video_next            = VIDEO_KEEP;
        body_next             = BODY_NONE;

        case (frame_id_reg)
            ID_DIAG_REPLY: begin
                if (b1_reg == DIAG_MODULE_ADDR && b4_reg == DIAG_BATTERY) begin
                    battery_next = times25[12:1];
                end
                if (b1_reg == DIAG_MODULE_ADDR && b4_reg == DIAG_MILEAGE) begin
                    mileage_next = {b5_reg, b6_reg, b7_reg, 8'd0};
                end
            end
            ID_REMOTE: begin
                if (b3_reg[7:4] == KEY_LOCK) begin
                    lock_last_next  = now_reg;
                    lock_count_next = lock_press.count;
                    if (lock_press.fire) begin
                        body_next = BODY_CLOSE;
                    end
                end else if (b3_reg[7:4] == KEY_UNLOCK) begin
                    unlock_last_next  = now_reg;
                    unlock_count_next = unlock_press.count;
                    body_next = unlock_press.fire ? BODY_LIGHTS_OPEN : BODY_LIGHTS;
                end
            end
            ID_WHEEL: begin
                if (b7_reg == MEDIA_RAISE && b5_reg == CRUISE_RAISE) begin
                    disp_next         = DISP_RAISE;
                    keep_display_next = 1'b1;
                end else if (b7_reg == MEDIA_LOWER && b5_reg == CRUISE_LOWER) begin
                    disp_next         = DISP_LOWER;
                    keep_display_next = 1'b0;
                end
                if (b6_reg == NAV_RELEASE) begin
                    nav_held_next = 1'b0;
                end
                if (b7_reg == MEDIA_RELEASE) begin
                    media_held_next = 1'b0;
                end
                if (!media_held_next) begin
                    if (b7_reg == MEDIA_NEXT_BT) begin
                        media_next      = MEDIA_NEXT;
                        media_held_next = 1'b1;
                    end else if (b7_reg == MEDIA_PREV_BT) begin
                        media_next      = MEDIA_PREV;
                        media_held_next = 1'b1;
                    end
                end
                if (!nav_held_next) begin
                    case (b6_reg)
                        NAV_UP_BT:    nav_next = NAV_UP;
                        NAV_DOWN_BT:  nav_next = NAV_DOWN;
                        NAV_LEFT_BT:  nav_next = NAV_LEFT;
                        NAV_RIGHT_BT: nav_next = NAV_RIGHT;
                        NAV_BACK_BT:  nav_next = NAV_BACK;
                        NAV_ENTER_BT: nav_next = NAV_ENTER;
                        default:      nav_next = NAV_NONE;
                    endcase
                    if (nav_next != NAV_NONE) begin
                        nav_held_next = 1'b1;
                    end
                end
            end
            ID_CLIMATE: begin
                cabin_next = {b7_reg, 5'd0} - {2'd0, b7_reg, 3'd0} + {5'd0, b7_reg};
            end
            ID_BRIGHT: begin
                brightness_next = $signed({1'b0, b7_reg} - 9'd16);
                disp_next       = DISP_LEVEL;
            end
            ID_SPEED: begin
                speed_next   = {b6_reg[1:0], b7_reg[7:2]};
                reverse_next = b2_reg[5];
                if (b2_reg[5]) begin
                    disp_next             = DISP_REVERSE;
                    video_next            = VIDEO_CAMERA;
                    reverse_deadline_next = now_reg + {16'd0, reverse_hold_reg};
                end else if (rev_dist != 32'd0 && !rev_dist[31]) begin
                    if (keep_display_reg) begin
                        disp_next  = DISP_RAISE;
                        video_next = VIDEO_COMPUTER;
                    end else begin
                        disp_next = DISP_LOWER;
                    end
                end
            end
            ID_RPM: begin
                rpm_next = {b6_reg[3:0], b7_reg};
            end
            default: ;
        endcase

        level_next = (disp_next != DISP_NONE) ? brightness_next + 9'sd2 : 9'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            media_held_reg       <= 1'b0;
            nav_held_reg         <= 1'b0;
            keep_display_reg     <= 1'b0;
            brightness_reg       <= 9'sd0;
            reverse_deadline_reg <= 32'd0;
            lock_last_reg        <= 32'd0;
            lock_count_reg       <= 2'd0;
            unlock_last_reg      <= 32'd0;
            unlock_count_reg     <= 2'd0;
            battery_reg          <= 12'd0;
            mileage_reg          <= 32'd0;
            cabin_reg            <= CABIN_RESET;
            speed_reg            <= 8'd0;
            rpm_reg              <= 12'd0;
            reverse_reg          <= 1'b0;
        end else if (fire) begin
            media_held_reg       <= media_held_next;
            nav_held_reg         <= nav_held_next;
            keep_display_reg     <= keep_display_next;
            brightness_reg       <= brightness_next;
            reverse_deadline_reg <= reverse_deadline_next;
            lock_last_reg        <= lock_last_next;
            lock_count_reg       <= lock_count_next;
            unlock_last_reg      <= unlock_last_next;
            unlock_count_reg     <= unlock_count_next;
            battery_reg          <= battery_next;
            mileage_reg          <= mileage_next;
            cabin_reg            <= cabin_next;
            speed_reg            <= speed_next;
            rpm_reg              <= rpm_next;
            reverse_reg          <= reverse_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            media_reg <= media_next;
            nav_reg   <= nav_next;
            disp_reg  <= disp_next;
            level_reg <= level_next;
            video_reg <= video_next;
            body_reg  <= body_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_media_event   = media_reg;
    assign m_nav_event     = nav_reg;
    assign m_display_cmd   = disp_reg;
    assign m_display_level = level_reg;
    assign m_video_select  = video_reg;
    assign m_body_action   = body_reg;
    assign m_speed_value   = speed_reg;
    assign m_rpm_value     = rpm_reg;
    assign m_battery_value = battery_reg;
    assign m_mileage_value = mileage_reg;
    assign m_cabin_value   = cabin_reg;
    assign m_reverse_flag  = reverse_reg;

endmodule

@@ src/vfed_checker.sv @@
module vfed_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_media_event,
    input logic [2:0]         m_nav_event,
    input logic [2:0]         m_display_cmd,
    input logic signed [8:0]  m_display_level,
    input logic [1:0]         m_video_select,
    input logic [1:0]         m_body_action,
    input logic               m_reverse_flag
);
    import vfed_pkg::*;

    // A stalled result transfer keeps its events.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_media_event) && $stable(m_nav_event)
            && $stable(m_display_cmd) && $stable(m_body_action))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_display_cmd == DISP_NONE |-> m_display_level == 9'sd0)
        else $error("display level without a display command");

    // Camera selection comes only from a speed frame that shows reverse gear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_video_select == VIDEO_CAMERA |-> m_display_cmd == DISP_REVERSE
            && m_reverse_flag)
        else $error("camera selected outside reverse");

    // Button events come only from wheel frames, which raise no body or video action.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_media_event != MEDIA_NONE || m_nav_event != NAV_NONE)
            |-> m_body_action == BODY_NONE && m_video_select == VIDEO_KEEP)
        else $error("button event mixed with another frame's action");

endmodule

bind vehicle_frame_event_decoder vfed_checker u_vfed_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_media_event   (m_media_event),
    .m_nav_event     (m_nav_event),
    .m_display_cmd   (m_display_cmd),
    .m_display_level (m_display_level),
    .m_video_select  (m_video_select),
    .m_body_action   (m_body_action),
    .m_reverse_flag  (m_reverse_flag)
);
